/* sv/circular_next_greater_element_defines.svh */
// Assertion macros for the top-level design file.
`ifndef CIRCULAR_NEXT_GREATER_ELEMENT_DEFINES_SVH
`define CIRCULAR_NEXT_GREATER_ELEMENT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CNGE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define CNGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cnge_pkg.sv */
`default_nettype none

package cnge_pkg;

    // Default sizing of the sequence store and of the stored values.
    localparam int MAX_LEN_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the value fields on both channels.
    localparam int VAL_W = 32;

    // One input word.
    typedef struct packed {
        logic signed [VAL_W-1:0] elem_value;
        logic                    elem_last;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic signed [VAL_W-1:0] greater_value;
        logic                    greater_found;
        logic                    seq_overflow;
        logic                    result_last;
    } t_out_word;

endpackage

`default_nettype wire

/* sv/cnge_ram.sv */
`default_nettype none

module cnge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/circular_next_greater_element.sv */
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+----------------------------
//  in      | into      | i_in_valid / o_in_stall   | i_in_word  (t_in_word)
//  out     | out of    | o_out_valid / i_out_stall | o_out_word (t_out_word)
//
//  Loading takes one word per cycle. A word marked last starts the compute pass for
//  the n stored values: the stack is prefilled with a read and a write per element,
//  each element is then read and compared, each pop (at most 2n pops) waits for the
//  registered read of the entry below the top, and each result is read, then loaded.
//  Reset is synchronous and active low and clears the control state only.
//  The input stalls from the last word until the final result is in the output register;
//  a stalled output holds its word and the results wait in the answer memory.
`default_nettype none
`include "circular_next_greater_element_defines.svh"

module circular_next_greater_element #(
    parameter int MAX_LEN    = cnge_pkg::MAX_LEN_DEF,
    parameter int DATA_WIDTH = cnge_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire cnge_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output cnge_pkg::t_out_word      o_out_word
);

    import cnge_pkg::*;

    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW     = $clog2(MAX_LEN + 1);
    localparam int SDEPTH = 2 * MAX_LEN;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int SPW    = $clog2(SDEPTH + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PF_RD,
        S_PF_WR,
        S_CUR_RD,
        S_CMP,
        S_POP_WAIT,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_ovf, n_ovf;
    logic [AW-1:0]         r_idx, n_idx;
    logic [SPW-1:0]        r_sp, n_sp;
    logic [DATA_WIDTH-1:0] r_top, n_top;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word, n_out_word;

    // Memory ports.
    logic                  val_we;
    logic [DATA_WIDTH-1:0] val_wdata, val_rdata;
    logic                  stk_we;
    logic [SAW-1:0]        stk_raddr;
    logic [DATA_WIDTH-1:0] stk_rdata;
    logic                  ans_we;
    logic [DATA_WIDTH:0]   ans_wdata, ans_rdata;

    logic                  in_acc;
    logic                  out_free;
    logic                  pop;
    logic                  idx_end;
    logic [CW-1:0]         cnt_inc;
    logic [SPW-1:0]        sp_m2;
    logic [63:0]           in_ext;
    logic [DATA_WIDTH+31:0] ans_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Input value cut or zero-extended to the stored width.
    assign in_ext    = {32'b0, i_in_word.elem_value};
    assign val_wdata = in_ext[DATA_WIDTH-1:0];
    assign val_we    = in_acc && (r_cnt < CW'(MAX_LEN));
    assign cnt_inc   = r_cnt + CW'(1);

    // The element under test pops the top while it is not smaller than it.
    assign pop = (r_sp != '0) && ($signed(val_rdata) >= $signed(r_top));

    // The entry below the top, read ahead for a pop.
    assign sp_m2     = r_sp - SPW'(2);
    assign stk_raddr = (r_sp >= SPW'(2)) ? sp_m2[SAW-1:0] : '0;
    assign stk_we    = (r_state == S_PF_WR) || ((r_state == S_CMP) && !pop);

    // Answer word: found flag above the value.
    assign ans_we    = (r_state == S_CMP) && !pop;
    assign ans_wdata = (r_sp == '0) ? '0 : {1'b1, r_top};
    assign ans_ext   = {32'b0, ans_rdata[DATA_WIDTH-1:0]};

    // Last stored element during emission.
    assign idx_end = (CW'(r_idx) == r_cnt - CW'(1));

    cnge_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(MAX_LEN)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(val_wdata),
        .i_raddr(r_idx),
        .o_rdata(val_rdata)
    );

    // Stack entries; the top is also kept in r_top.
    cnge_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(SDEPTH)
    ) u_stk_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(r_sp[SAW-1:0]),
        .i_wdata(val_rdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    cnge_ram #(
        .WIDTH(DATA_WIDTH + 1),
        .DEPTH(MAX_LEN)
    ) u_ans_ram (
        .i_clk  (i_clk),
        .i_we   (ans_we),
        .i_waddr(r_idx),
        .i_wdata(ans_wdata),
        .i_raddr(r_idx),
        .o_rdata(ans_rdata)
    );

    // Sequencer: load, stack prefill, scan from the end, then emission.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_sp        = r_sp;
        n_top       = r_top;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (val_we) begin
                        n_cnt = cnt_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_word.elem_last) begin
                        n_idx   = val_we ? r_cnt[AW-1:0] : AW'(MAX_LEN - 1);
                        n_sp    = '0;
                        n_state = S_PF_RD;
                    end
                end
            end
            S_PF_RD: begin
                n_state = S_PF_WR;
            end
            S_PF_WR: begin
                n_top = val_rdata;
                n_sp  = r_sp + SPW'(1);
                if (r_idx == '0) begin
                    n_idx   = AW'(r_cnt - CW'(1));
                    n_state = S_CUR_RD;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PF_RD;
                end
            end
            S_CUR_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (pop) begin
                    n_sp    = r_sp - SPW'(1);
                    n_state = S_POP_WAIT;
                end else begin
                    n_top = val_rdata;
                    n_sp  = r_sp + SPW'(1);
                    if (r_idx == '0) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_CUR_RD;
                    end
                end
            end
            S_POP_WAIT: begin
                n_top   = stk_rdata;
                n_state = S_CMP;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_word.greater_value   = ans_ext[31:0];
                    n_out_word.greater_found   = ans_rdata[DATA_WIDTH];
                    n_out_word.seq_overflow    = r_ovf;
                    n_out_word.result_last     = idx_end;
                    if (idx_end) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_idx   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_top      <= n_top;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The stack never grows past twice the maximum sequence length.
    `CNGE_ASSERT_ALWAYS(a_sp_bound, r_sp <= SPW'(SDEPTH), "stack depth past capacity")

    // The fill count never passes the store depth.
    `CNGE_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= CW'(MAX_LEN), "fill count past capacity")

    // A last word starts the prefill with an empty stack.
    `CNGE_ASSERT_NEXT(a_last_starts, in_acc && i_in_word.elem_last,
        (r_state == S_PF_RD) && (r_sp == '0), "last word did not start the compute pass")

    // Loading the final result clears the sequence state.
    `CNGE_ASSERT_NEXT(a_last_clears, (r_state == S_EMIT_LD) && out_free && idx_end,
        (r_cnt == '0) && !r_ovf && o_out_valid && o_out_word.result_last,
        "sequence state not cleared after the final result")

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    import cnge_pkg::*;

    localparam int PERIOD_NS     = 12;
    localparam int CAPACITY      = MAX_LEN_DEF;
    localparam int TOTAL_WORDS   = 260;
    localparam int CALM_WORDS    = 40;
    localparam int HOLD_AT       = 50;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 700;
    localparam int DIR_N         = 22;

    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh80000000;

    // One row of the directed table. Where typed is set, the answer for this
    // position is written in by hand instead of taken from the predictor.
    typedef struct {
        logic signed [VAL_W-1:0] val;
        bit                      last;
        bit                      typed;
        logic signed [VAL_W-1:0] want_val;
        bit                      want_found;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Predictor state: the sequence loaded so far and the dropped-word flag.
    logic signed [VAL_W-1:0] held_vals[CAPACITY];
    int                      held_n  = 0;
    bit                      spilled = 1'b0;
    t_out_word               fresh[CAPACITY];

    // Expected results; new ones enter at the front, the oldest leaves at the back.
    t_out_word pending_answers[$];
    int        words_taken  = 0;
    int        mismatch_cnt = 0;
    bit        calm         = 1'b0;
    bit        hold_done    = 1'b0;

    circular_next_greater_element u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #(PERIOD_NS / 2) i_clk = ~i_clk;

    // Absorb one element; on the last one, compute the circular next greater
    // value for every stored position into fresh[] and return how many.
    function automatic int ngreater_absorb(input logic signed [VAL_W-1:0] v, input bit last);
        logic signed [VAL_W-1:0] stk[$];
        int n;
        if (held_n < CAPACITY) begin
            held_vals[held_n] = v;
            held_n++;
        end else begin
            spilled = 1'b1;
        end
        if (!last) return 0;
        n = held_n;
        // The stack top is stk[0]. Prefill so that the first element sits on
        // top; this gives the wrap.
        for (int i = n - 1; i >= 0; i--) stk.push_front(held_vals[i]);
        for (int i = n - 1; i >= 0; i--) begin
            while (stk.size() > 0 && held_vals[i] >= stk[0]) void'(stk.pop_front());
            fresh[i].greater_value = (stk.size() > 0) ? stk[0] : '0;
            fresh[i].greater_found = (stk.size() > 0);
            fresh[i].seq_overflow  = spilled;
            fresh[i].result_last   = (i == n - 1);
            stk.push_front(held_vals[i]);
        end
        held_n  = 0;
        spilled = 1'b0;
        return n;
    endfunction

    // Values lean toward the extremes and a narrow band, so ties are common.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VMAX;
            1:       return VMIN;
            2, 3, 4: return int'($urandom_range(0, 8)) - 4;
            5:       return $urandom_range(0, 1) ? 0 : -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic file_answers(input int n);
        for (int k = 0; k < n; k++) pending_answers.push_front(fresh[k]);
    endtask

    task automatic note_error(input string what, input t_out_word want, input t_out_word got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s: want val=%0d found=%0b ovf=%0b last=%0b, got val=%0d found=%0b ovf=%0b last=%0b",
                     what, want.greater_value, want.greater_found, want.seq_overflow,
                     want.result_last, got.greater_value, got.greater_found,
                     got.seq_overflow, got.result_last);
    endtask

    // Offer one word, with an occasional gap before it, and wait until taken.
    task automatic send_word(input logic signed [VAL_W-1:0] v, input bit last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{elem_value: v, elem_last: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_taken++;
    endtask

    // Result checker: every accepted word is matched against the oldest answer.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                note_error("unexpected result", '0, o_out_word);
            end else begin
                want = pending_answers.pop_back();
                if (o_out_word.greater_value !== want.greater_value ||
                    o_out_word.greater_found !== want.greater_found ||
                    o_out_word.seq_overflow  !== want.seq_overflow  ||
                    o_out_word.result_last   !== want.result_last)
                    note_error("mismatch", want, o_out_word);
            end
        end
    end

    // Output side: random stall bursts, plus one long hold-off early on so
    // the block backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_taken >= HOLD_AT) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    initial begin
        #(PERIOD_NS * 300000);
        $display("tb: errors");
        $finish;
    end

    initial begin
        t_dir_row dir_rows[DIR_N];
        int       n;
        int       seq_first;
        int       seq_no;
        int       len;

        // Single elements, the two extremes, ties, a wrap-around case, then
        // mixed sequences left to the predictor.
        dir_rows = '{
            '{0,      1'b1, 1'b1, 0,    1'b0},
            '{VMAX,   1'b1, 1'b1, 0,    1'b0},
            '{VMIN,   1'b1, 1'b1, 0,    1'b0},
            '{VMIN,   1'b0, 1'b1, VMAX, 1'b1},
            '{VMAX,   1'b1, 1'b1, 0,    1'b0},
            '{5,      1'b0, 1'b1, 0,    1'b0},
            '{5,      1'b0, 1'b1, 0,    1'b0},
            '{5,      1'b1, 1'b1, 0,    1'b0},
            '{3,      1'b0, 1'b1, 0,    1'b0},
            '{1,      1'b0, 1'b1, 2,    1'b1},
            '{2,      1'b1, 1'b1, 3,    1'b1},
            '{-1,     1'b0, 1'b0, 0,    1'b0},
            '{7,      1'b0, 1'b0, 0,    1'b0},
            '{-8,     1'b0, 1'b0, 0,    1'b0},
            '{2,      1'b0, 1'b0, 0,    1'b0},
            '{-2147483647, 1'b0, 1'b0, 0, 1'b0},
            '{32'sh40000000, 1'b0, 1'b0, 0, 1'b0},
            '{-1,     1'b1, 1'b0, 0,    1'b0},
            '{4,      1'b0, 1'b0, 0,    1'b0},
            '{3,      1'b0, 1'b0, 0,    1'b0},
            '{2,      1'b0, 1'b0, 0,    1'b0},
            '{1,      1'b1, 1'b0, 0,    1'b0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        seq_first = 0;
        for (int r = 0; r < DIR_N; r++) begin
            send_word(dir_rows[r].val, dir_rows[r].last);
            n = ngreater_absorb(dir_rows[r].val, dir_rows[r].last);
            if (dir_rows[r].last) begin
                for (int k = 0; k < n; k++) begin
                    if (dir_rows[seq_first + k].typed) begin
                        fresh[k].greater_value = dir_rows[seq_first + k].want_val;
                        fresh[k].greater_found = dir_rows[seq_first + k].want_found;
                        fresh[k].seq_overflow  = 1'b0;
                        fresh[k].result_last   = (k == n - 1);
                    end
                end
                file_answers(n);
                seq_first = r + 1;
            end
        end

        // Random sequences, mostly short; one runs past capacity so that a
        // plain word and the last word are both dropped.
        seq_no = 0;
        while (words_taken < TOTAL_WORDS) begin
            if (seq_no == 2)
                len = CAPACITY + 2;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 30);
            else
                len = $urandom_range(1, 10);
            for (int e = 0; e < len; e++) begin
                logic signed [VAL_W-1:0] v;
                v = pick_value();
                if (words_taken >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;
                send_word(v, e == len - 1);
                n = ngreater_absorb(v, e == len - 1);
                file_answers(n);
            end
            seq_no++;
        end
        i_in_valid <= 1'b0;

        // Drain, then watch a while longer for stray results.
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_answers.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/cnge_pkg.sv
sv/cnge_ram.sv
sv/circular_next_greater_element.sv
sim/tb.sv
